@@ sv/particle_elastic_collision_step_assert.svh @@
// Assertion macros used by the collision step top level.
`ifndef PARTICLE_ELASTIC_COLLISION_STEP_ASSERT_SVH
`define PARTICLE_ELASTIC_COLLISION_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pec_pkg.sv @@
// Types, constants and helper functions of the elastic collision step.
package pec_pkg;

    localparam int POS_W     = 24;
    localparam int VEL_W     = 16;
    localparam int BOX_W     = 24;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 8;
    localparam int MASS_W    = 7;
    localparam int RAD_W     = 12;
    localparam int DX_W      = 13;
    localparam int DV_W      = 17;
    localparam int SQ_W      = 24;
    localparam int PROD_W    = 30;
    localparam int D2_W      = 25;
    localparam int DOT_W     = 31;
    localparam int MAG_W     = 42;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 30;
    localparam int Q_W       = 19;
    localparam int SUM_W     = 21;
    localparam int FRONT_STAGES = 5;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_LEFT   = 8'd0,
        REG_BOX_RIGHT  = 8'd1,
        REG_BOX_TOP    = 8'd2,
        REG_BOX_BOTTOM = 8'd3
    } t_reg_idx;

    localparam logic signed [BOX_W-1:0] BOX_LEFT_RST   = 24'sd0;
    localparam logic signed [BOX_W-1:0] BOX_RIGHT_RST  = 24'sd163840;
    localparam logic signed [BOX_W-1:0] BOX_TOP_RST    = 24'sd0;
    localparam logic signed [BOX_W-1:0] BOX_BOTTOM_RST = 24'sd122880;

    typedef struct packed {
        logic signed [BOX_W-1:0] left;
        logic signed [BOX_W-1:0] right;
        logic signed [BOX_W-1:0] top;
        logic signed [BOX_W-1:0] bottom;
    } t_box;

    typedef struct packed {
        logic                    action;
        logic signed [POS_W-1:0] pos_x_a;
        logic signed [POS_W-1:0] pos_y_a;
        logic signed [VEL_W-1:0] vel_x_a;
        logic signed [VEL_W-1:0] vel_y_a;
        logic [KIND_W-1:0]       kind_a;
        logic signed [POS_W-1:0] pos_x_b;
        logic signed [POS_W-1:0] pos_y_b;
        logic signed [VEL_W-1:0] vel_x_b;
        logic signed [VEL_W-1:0] vel_y_b;
        logic [KIND_W-1:0]       kind_b;
    } t_in;

    typedef struct packed {
        logic signed [VEL_W-1:0] new_vel_x_a;
        logic signed [VEL_W-1:0] new_vel_y_a;
        logic signed [VEL_W-1:0] new_vel_x_b;
        logic signed [VEL_W-1:0] new_vel_y_b;
        logic signed [POS_W-1:0] new_pos_x_a;
        logic signed [POS_W-1:0] new_pos_y_a;
        logic                    collided;
    } t_out;

    // Working set of one item as it moves down the pipeline.
    typedef struct packed {
        logic                     act;
        logic                     hit;
        logic                     inr;
        logic                     flx;
        logic                     fly;
        logic [MASS_W-1:0]        ma;
        logic [MASS_W-1:0]        mb;
        logic [RAD_W-1:0]         rs;
        logic [SQ_W-1:0]          rs2;
        logic signed [POS_W-1:0]  pxa;
        logic signed [POS_W-1:0]  pya;
        logic signed [VEL_W-1:0]  vxa;
        logic signed [VEL_W-1:0]  vya;
        logic signed [VEL_W-1:0]  vxb;
        logic signed [VEL_W-1:0]  vyb;
        logic signed [DX_W-1:0]   dx;
        logic signed [DX_W-1:0]   dy;
        logic signed [DV_W-1:0]   dvx;
        logic signed [DV_W-1:0]   dvy;
        logic [SQ_W-1:0]          xx;
        logic [SQ_W-1:0]          yy;
        logic signed [PROD_W-1:0] px;
        logic signed [PROD_W-1:0] py;
        logic [D2_W-1:0]          d2;
        logic signed [DOT_W-1:0]  dot;
        logic [MAG_W-1:0]         mx;
        logic [MAG_W-1:0]         my;
        logic [DEN_W-1:0]         den;
        logic                     negx;
        logic                     negy;
    } t_item;

    typedef logic [DEN_W-1:0] t_rem;
    typedef logic [Q_W-1:0]   t_quo;
    typedef logic [NUM_W-1:0] t_num;
    typedef t_rem [3:0] t_rem4;
    typedef t_quo [3:0] t_quo4;
    typedef t_num [3:0] t_num4;

    typedef struct packed {
        t_rem rem;
        t_quo lo;
    } t_dstep;

    // Mass per particle kind; the unused kind behaves as red.
    function automatic logic [MASS_W-1:0] kind_mass(input logic [KIND_W-1:0] k);
        logic [MASS_W-1:0] m;
        case (k)
            2'd1:    m = 7'd10;
            2'd2:    m = 7'd40;
            default: m = 7'd1;
        endcase
        return m;
    endfunction

    // Radius per particle kind in Q.8.
    function automatic logic [RAD_W-1:0] kind_rad(input logic [KIND_W-1:0] k);
        logic [RAD_W-1:0] r;
        case (k)
            2'd1:    r = 12'd1024;
            2'd2:    r = 12'd1536;
            default: r = 12'd512;
        endcase
        return r;
    endfunction

    // Negation that saturates the most negative velocity.
    function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
            r = {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            r = -v;
        end
        return r;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] x);
        logic signed [VEL_W-1:0] r;
        if (x[SUM_W-1:VEL_W-1] != {(SUM_W-VEL_W+1){x[SUM_W-1]}}) begin
            r = x[SUM_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            r = x[VEL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] x);
        logic signed [POS_W-1:0] r;
        if (x[POS_W] != x[POS_W-1]) begin
            r = x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = x[POS_W-1:0];
        end
        return r;
    endfunction

    // One restoring division step: bring in the next numerator bit.
    function automatic t_dstep div_step(input t_rem rem, input t_quo lo, input t_rem den);
        logic [DEN_W:0] r2;
        t_dstep         s;
        r2 = {rem, lo[Q_W-1]};
        if (r2 >= {1'b0, den}) begin
            s.rem = DEN_W'(r2 - {1'b0, den});
            s.lo  = {lo[Q_W-2:0], 1'b1};
        end else begin
            s.rem = r2[DEN_W-1:0];
            s.lo  = {lo[Q_W-2:0], 1'b0};
        end
        return s;
    endfunction

endpackage

@@ sv/pec_if.sv @@
// Channel interfaces of the elastic collision step.
interface pec_in_if;
    logic          valid;
    logic          ready;
    pec_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pec_out_if;
    logic          valid;
    logic          ready;
    pec_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pec_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pec_pkg::CFG_IDX_W-1:0]     index;
    logic signed [pec_pkg::BOX_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/pec_front.sv @@
// Geometry front end: differences, products, contact test, wall reflection, position advance and numerators.
module pec_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  pec_pkg::t_in        i_data,
    input  pec_pkg::t_box       i_box,
    output logic                o_valid,
    output pec_pkg::t_item      o_item,
    output pec_pkg::t_num4      o_num
);

    logic [pec_pkg::FRONT_STAGES-1:0] r_v;
    pec_pkg::t_item r_a, r_b, r_c, r_d, r_e;
    pec_pkg::t_item n_a, n_b, n_c, n_d, n_e;
    pec_pkg::t_num4 r_num, n_num;

    // Stage A: differences, radius sum, range test and wall flags.
    always_comb begin
        logic signed [pec_pkg::POS_W:0]   dx25, dy25, rsw;
        logic signed [pec_pkg::POS_W+1:0] px26, py26, ra26;
        logic signed [pec_pkg::POS_W+1:0] lo_x, hi_x, lo_y, hi_y;
        logic [pec_pkg::RAD_W-1:0]        ra;
        n_a     = '0;
        n_a.act = i_data.action;
        n_a.ma  = pec_pkg::kind_mass(i_data.kind_a);
        n_a.mb  = pec_pkg::kind_mass(i_data.kind_b);
        ra      = pec_pkg::kind_rad(i_data.kind_a);
        n_a.rs  = ra + pec_pkg::kind_rad(i_data.kind_b);
        n_a.pxa = i_data.pos_x_a;
        n_a.pya = i_data.pos_y_a;
        n_a.vxa = i_data.vel_x_a;
        n_a.vya = i_data.vel_y_a;
        n_a.vxb = i_data.vel_x_b;
        n_a.vyb = i_data.vel_y_b;
        dx25 = {i_data.pos_x_a[pec_pkg::POS_W-1], i_data.pos_x_a}
             - {i_data.pos_x_b[pec_pkg::POS_W-1], i_data.pos_x_b};
        dy25 = {i_data.pos_y_a[pec_pkg::POS_W-1], i_data.pos_y_a}
             - {i_data.pos_y_b[pec_pkg::POS_W-1], i_data.pos_y_b};
        rsw  = $signed({{(pec_pkg::POS_W+1-pec_pkg::RAD_W){1'b0}}, n_a.rs});
        n_a.inr = (dx25 != '0 || dy25 != '0) && dx25 <= rsw && dx25 >= -rsw
                  && dy25 <= rsw && dy25 >= -rsw;
        n_a.dx  = dx25[pec_pkg::DX_W-1:0];
        n_a.dy  = dy25[pec_pkg::DX_W-1:0];
        n_a.dvx = {i_data.vel_x_a[pec_pkg::VEL_W-1], i_data.vel_x_a}
                - {i_data.vel_x_b[pec_pkg::VEL_W-1], i_data.vel_x_b};
        n_a.dvy = {i_data.vel_y_a[pec_pkg::VEL_W-1], i_data.vel_y_a}
                - {i_data.vel_y_b[pec_pkg::VEL_W-1], i_data.vel_y_b};
        // Wall reflection tests at full precision.
        px26 = {{2{i_data.pos_x_a[pec_pkg::POS_W-1]}}, i_data.pos_x_a};
        py26 = {{2{i_data.pos_y_a[pec_pkg::POS_W-1]}}, i_data.pos_y_a};
        ra26 = $signed({{(pec_pkg::POS_W+2-pec_pkg::RAD_W){1'b0}}, ra});
        lo_x = {{2{i_box.left[pec_pkg::BOX_W-1]}}, i_box.left} + ra26;
        hi_x = {{2{i_box.right[pec_pkg::BOX_W-1]}}, i_box.right} - ra26;
        lo_y = {{2{i_box.top[pec_pkg::BOX_W-1]}}, i_box.top} + ra26;
        hi_y = {{2{i_box.bottom[pec_pkg::BOX_W-1]}}, i_box.bottom} - ra26;
        n_a.flx = (px26 <= lo_x && i_data.vel_x_a < 0) || (px26 >= hi_x && i_data.vel_x_a > 0);
        n_a.fly = (py26 <= lo_y && i_data.vel_y_a < 0) || (py26 >= hi_y && i_data.vel_y_a > 0);
    end

    // Stage B: squares and velocity-position products; wall reflection.
    always_comb begin
        logic signed [2*pec_pkg::DX_W-1:0] sqx, sqy;
        n_b     = r_a;
        sqx     = r_a.dx * r_a.dx;
        sqy     = r_a.dy * r_a.dy;
        n_b.xx  = sqx[pec_pkg::SQ_W-1:0];
        n_b.yy  = sqy[pec_pkg::SQ_W-1:0];
        n_b.px  = r_a.dvx * r_a.dx;
        n_b.py  = r_a.dvy * r_a.dy;
        n_b.rs2 = r_a.rs * r_a.rs;
        if (r_a.act && r_a.flx) begin
            n_b.vxa = pec_pkg::neg_vel(r_a.vxa);
        end
        if (r_a.act && r_a.fly) begin
            n_b.vya = pec_pkg::neg_vel(r_a.vya);
        end
    end

    // Stage C: squared distance, dot product, collision decision; advance step.
    always_comb begin
        n_c     = r_b;
        n_c.d2  = {1'b0, r_b.xx} + {1'b0, r_b.yy};
        n_c.dot = {r_b.px[pec_pkg::PROD_W-1], r_b.px} + {r_b.py[pec_pkg::PROD_W-1], r_b.py};
        n_c.hit = !r_b.act && r_b.inr && (n_c.d2 <= {1'b0, r_b.rs2})
                  && n_c.dot[pec_pkg::DOT_W-1];
        if (r_b.act) begin
            n_c.pxa = pec_pkg::sat_pos({r_b.pxa[pec_pkg::POS_W-1], r_b.pxa}
                      + {{(pec_pkg::POS_W+1-pec_pkg::VEL_W){r_b.vxa[pec_pkg::VEL_W-1]}}, r_b.vxa});
            n_c.pya = pec_pkg::sat_pos({r_b.pya[pec_pkg::POS_W-1], r_b.pya}
                      + {{(pec_pkg::POS_W+1-pec_pkg::VEL_W){r_b.vya[pec_pkg::VEL_W-1]}}, r_b.vya});
        end
    end

    // Stage D: magnitudes of dot times offset, and the divisor.
    always_comb begin
        logic [pec_pkg::DOT_W-1:0]  adot;
        logic [pec_pkg::DX_W-1:0]   adx, ady;
        logic [pec_pkg::DEN_W:0]    dd;
        n_d      = r_c;
        adot     = r_c.dot[pec_pkg::DOT_W-1] ? -r_c.dot : r_c.dot;
        adx      = r_c.dx[pec_pkg::DX_W-1] ? -r_c.dx : r_c.dx;
        ady      = r_c.dy[pec_pkg::DX_W-1] ? -r_c.dy : r_c.dy;
        n_d.mx   = adot[pec_pkg::DOT_W-2:0] * adx[pec_pkg::DX_W-2:0];
        n_d.my   = adot[pec_pkg::DOT_W-2:0] * ady[pec_pkg::DX_W-2:0];
        dd       = pec_pkg::MASS_W'(r_c.ma + r_c.mb) * r_c.d2[pec_pkg::SQ_W-1:0];
        n_d.den  = dd[pec_pkg::DEN_W-1:0];
        n_d.negx = r_c.dot[pec_pkg::DOT_W-1] ^ r_c.dx[pec_pkg::DX_W-1];
        n_d.negy = r_c.dot[pec_pkg::DOT_W-1] ^ r_c.dy[pec_pkg::DX_W-1];
    end

    // Stage E: scale by twice the other particle's mass.
    always_comb begin
        logic [pec_pkg::MAG_W+pec_pkg::MASS_W:0] p0, p1, p2, p3;
        n_e      = r_d;
        p0       = r_d.mx * {r_d.mb, 1'b0};
        p1       = r_d.my * {r_d.mb, 1'b0};
        p2       = r_d.mx * {r_d.ma, 1'b0};
        p3       = r_d.my * {r_d.ma, 1'b0};
        n_num[0] = p0[pec_pkg::NUM_W-1:0];
        n_num[1] = p1[pec_pkg::NUM_W-1:0];
        n_num[2] = p2[pec_pkg::NUM_W-1:0];
        n_num[3] = p3[pec_pkg::NUM_W-1:0];
    end

    // Valid bits travel with the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[pec_pkg::FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_c   <= n_c;
            r_d   <= n_d;
            r_e   <= n_e;
            r_num <= n_num;
        end
    end

    assign o_valid = r_v[pec_pkg::FRONT_STAGES-1];
    assign o_item  = r_e;
    assign o_num   = r_num;

endmodule

@@ sv/pec_div.sv @@
// Four-lane pipelined restoring divider, one quotient bit per stage.
module pec_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  pec_pkg::t_item  i_item,
    input  pec_pkg::t_num4  i_num,
    output logic            o_valid,
    output pec_pkg::t_item  o_item,
    output pec_pkg::t_quo4  o_quo
);

    logic [pec_pkg::Q_W-1:0] r_v;
    pec_pkg::t_item r_item [pec_pkg::Q_W];
    pec_pkg::t_rem4 r_rem  [pec_pkg::Q_W];
    pec_pkg::t_quo4 r_lo   [pec_pkg::Q_W];
    pec_pkg::t_rem4 n_rem  [pec_pkg::Q_W];
    pec_pkg::t_quo4 n_lo   [pec_pkg::Q_W];

    // Each stage takes one step on every lane; stage zero loads the numerator.
    always_comb begin
        pec_pkg::t_dstep s;
        pec_pkg::t_rem   src_rem;
        pec_pkg::t_quo   src_lo;
        pec_pkg::t_rem   den;
        for (int k = 0; k < pec_pkg::Q_W; k++) begin
            for (int l = 0; l < 4; l++) begin
                if (k == 0) begin
                    src_rem = pec_pkg::DEN_W'(i_num[l][pec_pkg::NUM_W-1:pec_pkg::Q_W]);
                    src_lo  = i_num[l][pec_pkg::Q_W-1:0];
                    den     = i_item.den;
                end else begin
                    src_rem = r_rem[k-1][l];
                    src_lo  = r_lo[k-1][l];
                    den     = r_item[k-1].den;
                end
                s           = pec_pkg::div_step(src_rem, src_lo, den);
                n_rem[k][l] = s.rem;
                n_lo[k][l]  = s.lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[pec_pkg::Q_W-2:0], i_valid};
        end
    end

    // The item travels beside its partial quotients.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int k = 1; k < pec_pkg::Q_W; k++) begin
                r_item[k] <= r_item[k-1];
            end
            for (int k = 0; k < pec_pkg::Q_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
            end
        end
    end

    assign o_valid = r_v[pec_pkg::Q_W-1];
    assign o_item  = r_item[pec_pkg::Q_W-1];
    assign o_quo   = r_lo[pec_pkg::Q_W-1];

endmodule

@@ sv/particle_elastic_collision_step.sv @@
// Top level of the two-dimensional elastic collision and advance step.
//
// Words arrive on i_in (valid/ready); each word yields exactly one result
// word on o_out. Action 0 collides particles a and b, action 1 reflects
// particle a at the box walls and moves it by one velocity step.
// The box walls are written through i_cfg (index 0 left, 1 right, 2 top,
// 3 bottom); other indexes are ignored. Write them only while idle.
// From acceptance to the result being offered, a word passes five geometry
// stages, nineteen divider stages (one quotient bit per stage, set by the
// quotient width) and the output register.
// Throughput is one word per cycle while the skid register is empty; every stage moves on the same enable.
// When the receiver stalls, the output register holds its word and a skid
// register catches the one word already in flight; the pipeline then
// freezes until the skid register drains, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the default box.
module particle_elastic_collision_step (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pec_in_if.sink    i_in,
    pec_out_if.source o_out,
    pec_cfg_if.sink   i_cfg
);

`include "particle_elastic_collision_step_assert.svh"

    pec_pkg::t_box  r_box;
    logic           en;
    logic           f_valid, d_valid, inc;
    pec_pkg::t_item f_item, d_item;
    pec_pkg::t_num4 f_num;
    pec_pkg::t_quo4 d_quo;
    pec_pkg::t_out  n_res, r_out, r_skid;
    logic           r_ov, r_sv;

    // Box wall registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.left   <= pec_pkg::BOX_LEFT_RST;
            r_box.right  <= pec_pkg::BOX_RIGHT_RST;
            r_box.top    <= pec_pkg::BOX_TOP_RST;
            r_box.bottom <= pec_pkg::BOX_BOTTOM_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pec_pkg::REG_BOX_LEFT:   r_box.left   <= i_cfg.data;
                pec_pkg::REG_BOX_RIGHT:  r_box.right  <= i_cfg.data;
                pec_pkg::REG_BOX_TOP:    r_box.top    <= i_cfg.data;
                pec_pkg::REG_BOX_BOTTOM: r_box.bottom <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // The whole pipeline advances while the skid register is empty.
    assign en         = !r_sv;
    assign i_in.ready = en;

    pec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_data  (i_in.data),
        .i_box   (r_box),
        .o_valid (f_valid),
        .o_item  (f_item),
        .o_num   (f_num)
    );

    pec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_item  (f_item),
        .i_num   (f_num),
        .o_valid (d_valid),
        .o_item  (d_item),
        .o_quo   (d_quo)
    );

    // Apply the signed quotients and pick the result for the action.
    always_comb begin
        logic signed [pec_pkg::SUM_W-1:0] sx_a, sy_a, sx_b, sy_b;
        logic signed [pec_pkg::SUM_W-1:0] wva_x, wva_y, wvb_x, wvb_y;
        sx_a  = $signed({2'b00, d_quo[0]});
        sy_a  = $signed({2'b00, d_quo[1]});
        sx_b  = $signed({2'b00, d_quo[2]});
        sy_b  = $signed({2'b00, d_quo[3]});
        if (d_item.negx) begin
            sx_a = -sx_a;
            sx_b = -sx_b;
        end
        if (d_item.negy) begin
            sy_a = -sy_a;
            sy_b = -sy_b;
        end
        wva_x = {{(pec_pkg::SUM_W-pec_pkg::VEL_W){d_item.vxa[pec_pkg::VEL_W-1]}}, d_item.vxa};
        wva_y = {{(pec_pkg::SUM_W-pec_pkg::VEL_W){d_item.vya[pec_pkg::VEL_W-1]}}, d_item.vya};
        wvb_x = {{(pec_pkg::SUM_W-pec_pkg::VEL_W){d_item.vxb[pec_pkg::VEL_W-1]}}, d_item.vxb};
        wvb_y = {{(pec_pkg::SUM_W-pec_pkg::VEL_W){d_item.vyb[pec_pkg::VEL_W-1]}}, d_item.vyb};
        n_res.new_pos_x_a = d_item.pxa;
        n_res.new_pos_y_a = d_item.pya;
        n_res.collided    = d_item.hit;
        if (d_item.act) begin
            n_res.new_vel_x_a = d_item.vxa;
            n_res.new_vel_y_a = d_item.vya;
            n_res.new_vel_x_b = '0;
            n_res.new_vel_y_b = '0;
        end else if (d_item.hit) begin
            n_res.new_vel_x_a = pec_pkg::sat_vel(wva_x - sx_a);
            n_res.new_vel_y_a = pec_pkg::sat_vel(wva_y - sy_a);
            n_res.new_vel_x_b = pec_pkg::sat_vel(wvb_x + sx_b);
            n_res.new_vel_y_b = pec_pkg::sat_vel(wvb_y + sy_b);
        end else begin
            n_res.new_vel_x_a = d_item.vxa;
            n_res.new_vel_y_a = d_item.vya;
            n_res.new_vel_x_b = d_item.vxb;
            n_res.new_vel_y_b = d_item.vyb;
        end
    end

    assign inc = d_valid && en;

    // Output register with a one-word skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || o_out.ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= inc;
            end
        end else if (inc) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || o_out.ready) begin
            r_out <= r_sv ? r_skid : n_res;
        end else if (inc) begin
            r_skid <= n_res;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    `PEC_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_sv, r_ov, "skid full with output empty")
    `PEC_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_ov && !o_out.ready, r_ov && $stable(r_out), "stalled word changed")
    `PEC_ASSERT_NXT(a_no_loss, i_clk, i_rst_n, inc && r_ov && !o_out.ready, r_sv, "arriving word not caught")

endmodule

@@ tb/pec_scoreboard.sv @@
// Checker for the collision step: predicts each result word and compares it.
`timescale 1ns / 1ps

module pec_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    pec_in_if    in_ch,
    pec_out_if   out_ch,
    pec_cfg_if   cfg_ch,
    output int   o_errors,
    output int   o_pending,
    output int   o_hits,
    output int   o_advances
);

    pec_pkg::t_box walls;
    pec_pkg::t_out motion_q[$];

    // Saturate a wide value to a signed width.
    function automatic longint clamp(input longint x, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic longint mass_of(input logic [pec_pkg::KIND_W-1:0] k);
        case (k)
            2'd1:    return 10;
            2'd2:    return 40;
            default: return 1;
        endcase
    endfunction

    // Radius in Q.8; the unused kind counts as red.
    function automatic longint radius_of(input logic [pec_pkg::KIND_W-1:0] k);
        case (k)
            2'd1:    return 1024;
            2'd2:    return 1536;
            default: return 512;
        endcase
    endfunction

    // Truncated quotient of num*m/den, rounded towards zero.
    function automatic longint impulse(input longint num, input longint m, input longint den);
        longint a, q;
        a = (num < 0) ? -num : num;
        q = (a / den) * m + ((a % den) * m) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Wall bounce of one velocity component.
    function automatic longint bounce(input longint p, input longint v, input longint lo,
                                      input longint hi, input longint r);
        if ((p <= lo + r && v < 0) || (p >= hi - r && v > 0)) begin
            return clamp(-v, pec_pkg::VEL_W);
        end
        return v;
    endfunction

    function automatic pec_pkg::t_out predict_motion(input pec_pkg::t_in w,
                                                     input pec_pkg::t_box b);
        pec_pkg::t_out r;
        longint pxa, pya, vxa, vya, pxb, pyb, vxb, vyb, ra, rs;
        longint dx, dy, d2, dot, ma, mb, den;
        longint nvxa, nvya, nvxb, nvyb;
        pxa = w.pos_x_a; pya = w.pos_y_a; vxa = w.vel_x_a; vya = w.vel_y_a;
        pxb = w.pos_x_b; pyb = w.pos_y_b; vxb = w.vel_x_b; vyb = w.vel_y_b;
        ra = radius_of(w.kind_a);
        r = '0;
        r.new_pos_x_a = w.pos_x_a;
        r.new_pos_y_a = w.pos_y_a;
        if (w.action) begin
            nvxa = bounce(pxa, vxa, longint'(b.left), longint'(b.right), ra);
            nvya = bounce(pya, vya, longint'(b.top), longint'(b.bottom), ra);
            r.new_vel_x_a = nvxa;
            r.new_vel_y_a = nvya;
            r.new_pos_x_a = clamp(pxa + nvxa, pec_pkg::POS_W);
            r.new_pos_y_a = clamp(pya + nvya, pec_pkg::POS_W);
        end else begin
            r.new_vel_x_a = w.vel_x_a;
            r.new_vel_y_a = w.vel_y_a;
            r.new_vel_x_b = w.vel_x_b;
            r.new_vel_y_b = w.vel_y_b;
            dx = pxa - pxb;
            dy = pya - pyb;
            rs = ra + radius_of(w.kind_b);
            d2 = dx * dx + dy * dy;
            if ((dx != 0 || dy != 0) && d2 <= rs * rs) begin
                dot = (vxa - vxb) * dx + (vya - vyb) * dy;
                if (dot < 0) begin
                    ma = mass_of(w.kind_a);
                    mb = mass_of(w.kind_b);
                    den = (ma + mb) * d2;
                    r.new_vel_x_a = clamp(vxa - impulse(dot * dx, 2 * mb, den),
                                          pec_pkg::VEL_W);
                    r.new_vel_y_a = clamp(vya - impulse(dot * dy, 2 * mb, den),
                                          pec_pkg::VEL_W);
                    r.new_vel_x_b = clamp(vxb + impulse(dot * dx, 2 * ma, den),
                                          pec_pkg::VEL_W);
                    r.new_vel_y_b = clamp(vyb + impulse(dot * dy, 2 * ma, den),
                                          pec_pkg::VEL_W);
                    r.collided = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_hits = 0;
        o_advances = 0;
    end

    // Follow the configuration, queue predictions and retire result words.
    always @(posedge i_clk) begin
        pec_pkg::t_out e;
        pec_pkg::t_out g;
        if (!i_rst_n) begin
            walls = '{pec_pkg::BOX_LEFT_RST, pec_pkg::BOX_RIGHT_RST,
                      pec_pkg::BOX_TOP_RST, pec_pkg::BOX_BOTTOM_RST};
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                e = predict_motion(in_ch.data, walls);
                motion_q.push_back(e);
                if (e.collided) o_hits++;
                if (in_ch.data.action) o_advances++;
            end
            if (out_ch.valid && out_ch.ready) begin
                g = out_ch.data;
                if (motion_q.size() == 0) begin
                    $display("%0t: result word with nothing expected", $time);
                    o_errors++;
                end else begin
                    e = motion_q.pop_front();
                    check_field("new_vel_x_a", e.new_vel_x_a, g.new_vel_x_a);
                    check_field("new_vel_y_a", e.new_vel_y_a, g.new_vel_y_a);
                    check_field("new_vel_x_b", e.new_vel_x_b, g.new_vel_x_b);
                    check_field("new_vel_y_b", e.new_vel_y_b, g.new_vel_y_b);
                    check_field("new_pos_x_a", e.new_pos_x_a, g.new_pos_x_a);
                    check_field("new_pos_y_a", e.new_pos_y_a, g.new_pos_y_a);
                    check_field("collided", e.collided, g.collided);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    pec_pkg::REG_BOX_LEFT:   walls.left   = cfg_ch.data;
                    pec_pkg::REG_BOX_RIGHT:  walls.right  = cfg_ch.data;
                    pec_pkg::REG_BOX_TOP:    walls.top    = cfg_ch.data;
                    pec_pkg::REG_BOX_BOTTOM: walls.bottom = cfg_ch.data;
                    default: ;
                endcase
            end
        end
        o_pending = motion_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Stimulus and verdict for the elastic collision step testbench.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 25;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_req;
    int   hold_seen;
    int   hold_left;
    int   quiet_cycles;
    int   errors, pending, hits, advances, words;

    pec_in_if  in_ch ();
    pec_out_if out_ch ();
    pec_cfg_if cfg_ch ();

    particle_elastic_collision_step uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pec_scoreboard checker_u (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_ch     (cfg_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_hits     (hits),
        .o_advances (advances)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        hold_seen = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles in which no channel moves a word.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word after random idle cycles; valid stays high for the next word.
    task automatic send_word(input pec_pkg::t_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        words++;
    endtask

    // Offer one register write; the caller drops valid after the last one.
    task automatic write_reg(input logic [pec_pkg::CFG_IDX_W-1:0] idx,
                             input logic signed [pec_pkg::BOX_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Let every expected word drain before touching the registers.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic signed [pec_pkg::VEL_W-1:0] rand_vel();
        if ($urandom_range(3) == 0) return $urandom;
        return $signed($urandom_range(4095)) - 2048;
    endfunction

    // Random word: mostly pairs in or near contact and advances near the walls.
    function automatic pec_pkg::t_in make_word(input pec_pkg::t_box b);
        pec_pkg::t_in w;
        longint       cx, cy;
        int           sel;
        w = $urandom;
        w.pos_x_a = $urandom; w.pos_y_a = $urandom;
        w.pos_x_b = $urandom; w.pos_y_b = $urandom;
        w.vel_x_a = $urandom; w.vel_y_a = $urandom;
        w.vel_x_b = $urandom; w.vel_y_b = $urandom;
        w.kind_a = $urandom_range(3);
        w.kind_b = $urandom_range(3);
        w.action = $urandom_range(1);
        sel = $urandom_range(9);
        if (sel == 0) return w;
        w.vel_x_a = rand_vel(); w.vel_y_a = rand_vel();
        w.vel_x_b = rand_vel(); w.vel_y_b = rand_vel();
        if (!w.action) begin
            cx = longint'($urandom_range(200000)) - 100000;
            cy = longint'($urandom_range(200000)) - 100000;
            w.pos_x_a = cx;
            w.pos_y_a = cy;
            w.pos_x_b = cx + longint'($urandom_range(6400)) - 3200;
            w.pos_y_b = cy + longint'($urandom_range(6400)) - 3200;
        end else begin
            cx = $urandom_range(1) ? longint'(b.left) : longint'(b.right);
            cy = $urandom_range(1) ? longint'(b.top) : longint'(b.bottom);
            w.pos_x_a = cx + longint'($urandom_range(4000)) - 2000;
            w.pos_y_a = cy + longint'($urandom_range(4000)) - 2000;
        end
        return w;
    endfunction

    function automatic pec_pkg::t_in pair(input logic signed [pec_pkg::POS_W-1:0] px,
                                          input logic signed [pec_pkg::VEL_W-1:0] vx,
                                          input logic signed [pec_pkg::POS_W-1:0] qx,
                                          input logic signed [pec_pkg::VEL_W-1:0] ux,
                                          input logic [pec_pkg::KIND_W-1:0] ka,
                                          input logic [pec_pkg::KIND_W-1:0] kb);
        pec_pkg::t_in w;
        w = '0;
        w.pos_x_a = px; w.vel_x_a = vx; w.kind_a = ka;
        w.pos_x_b = qx; w.vel_x_b = ux; w.kind_b = kb;
        w.pos_y_a = 1000; w.pos_y_b = 1000;
        return w;
    endfunction

    function automatic pec_pkg::t_in step(input logic signed [pec_pkg::POS_W-1:0] px,
                                          input logic signed [pec_pkg::POS_W-1:0] py,
                                          input logic signed [pec_pkg::VEL_W-1:0] vx,
                                          input logic signed [pec_pkg::VEL_W-1:0] vy,
                                          input logic [pec_pkg::KIND_W-1:0] k);
        pec_pkg::t_in w;
        w = '0;
        w.action = 1'b1;
        w.pos_x_a = px; w.pos_y_a = py; w.vel_x_a = vx; w.vel_y_a = vy; w.kind_a = k;
        w.pos_x_b = -1; w.vel_y_b = -1; w.kind_b = 3;
        return w;
    endfunction

    initial begin
        pec_pkg::t_box cur;
        pec_pkg::t_box sets[5];
        int            idle_tab[4];
        int            stall_tab[4];
        pec_pkg::t_in  w;
        idle_tab  = '{0, 84, 0, 11};
        stall_tab = '{0, 0, 84, 11};
        sets[0] = '{pec_pkg::BOX_LEFT_RST, pec_pkg::BOX_RIGHT_RST,
                    pec_pkg::BOX_TOP_RST, pec_pkg::BOX_BOTTOM_RST};
        sets[1] = '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF};
        sets[2] = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000};
        sets[3] = '{-24'sd20000, 24'sd20000, -24'sd5000, 24'sd30000};
        sets[4] = '{24'sd0, 24'sd512, 24'sd0, 24'sd512};
        words = 0;
        hold_req = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cur = sets[0];

        // Directed words at the default box.
        send_word(pair(24'sd0, 16'sd256, 24'sd0, -16'sd256, 2'd0, 2'd0));       // same spot
        send_word(pair(24'sd0, 16'sd256, 24'sd800, -16'sd256, 2'd0, 2'd1));     // head on
        send_word(pair(24'sd0, -16'sd256, 24'sd800, 16'sd256, 2'd1, 2'd2));     // separating
        send_word(pair(24'sd0, 16'sd256, 24'sd5000, -16'sd256, 2'd2, 2'd2));    // too far
        send_word(pair(24'sd0, 16'sh7FFF, 24'sd100, 16'sh8000, 2'd0, 2'd2));    // saturates
        send_word(pair(24'sd0, 16'sh7FFF, 24'sd100, 16'sh8000, 2'd2, 2'd0));
        send_word(pair(24'sd3000, 16'sd1, 24'sd0, -16'sd1, 2'd3, 2'd3));        // unused kind
        send_word(pair(24'sh7FFFFF, 16'sd1, 24'sh7FFFFF - 24'sd600, 16'sd9, 2'd1, 2'd0));
        send_word(pair(24'sh800000, -16'sd9, 24'sh800000 + 24'sd600, 16'sd0, 2'd3, 2'd1));
        send_word(step(24'sd0, 24'sd0, 16'sh8000, 16'sh8000, 2'd0));            // negate min
        send_word(step(24'sd163840, 24'sd122880, 16'sh7FFF, 16'sh7FFF, 2'd2));
        send_word(step(24'sd80000, 24'sd60000, 16'sd300, -16'sd300, 2'd1));
        send_word(step(24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 16'sh8000, 2'd3));
        send_word(step(24'sh800000, 24'sh7FFFFF, 16'sh8000, 16'sh7FFF, 2'd1));
        send_word(step(24'sd512, 24'sd512, -16'sd1, 16'sd0, 2'd0));             // on the wall
        send_word(step(24'sd513, 24'sd122368, -16'sd1, 16'sd1, 2'd0));
        send_word(step(24'sh7FFFFF, 24'sh7FFFFF, 16'sd0, 16'sd0, 2'd2));
        drain();
        write_reg(8'd9, 24'sh123456);   // unknown index, ignored
        cfg_ch.valid <= 1'b0;
        send_word(step(24'sd0, 24'sd0, -16'sd5, -16'sd5, 2'd0));

        // Random phases across box settings and idle patterns.
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            cur = sets[ph % 5];
            if (ph == 11) begin
                cur.left = $urandom; cur.right = $urandom;
                cur.top = $urandom; cur.bottom = $urandom;
            end
            write_reg(pec_pkg::REG_BOX_LEFT, cur.left);
            write_reg(pec_pkg::REG_BOX_RIGHT, cur.right);
            write_reg(pec_pkg::REG_BOX_TOP, cur.top);
            write_reg(pec_pkg::REG_BOX_BOTTOM, cur.bottom);
            cfg_ch.valid <= 1'b0;
            send_idle_pct  = idle_tab[ph % 4];
            recv_stall_pct = stall_tab[ph % 4];
            if (ph == 4) hold_req++;
            for (int n = 0; n < 107; n++) begin
                w = make_word(cur);
                send_word(w);
            end
        end
        in_ch.valid <= 1'b0;

        // Wait for the tail of the pipeline, then give the verdict.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d words: %0d advances, %0d collisions with contact.",
                 words, advances, hits);
        $display("Box settings included the defaults, both extremes and a random one.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ particle_elastic_collision_step.f @@
+incdir+sv
sv/pec_pkg.sv
sv/pec_if.sv
sv/pec_front.sv
sv/pec_div.sv
sv/particle_elastic_collision_step.sv
tb/pec_scoreboard.sv
tb/tb_top.sv
